[rtl/bds_pkg.sv]
// ----------------------------------------------------------------------------
// bds_pkg: shared definitions of the 2x2 box downsampler
// Sizes, register indexes and the control bundle that drives each lane.
// ----------------------------------------------------------------------------
package bds_pkg;

    localparam int MAX_WIDTH       = 2048;
    localparam int CHANNEL_BITS    = 16;
    localparam int HEIGHT_LIMIT    = 4096;
    localparam int NUM_LANES       = 4;

    localparam int WIDTH_REG_BITS  = 12;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 13;

    localparam int LINE_DEPTH      = MAX_WIDTH / 2;
    localparam int IDX_BITS        = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int COL_BITS        = $clog2(MAX_WIDTH);
    localparam int ROW_BITS        = $clog2(HEIGHT_LIMIT);
    localparam int EFF_W_BITS      = $clog2(MAX_WIDTH + 1);
    localparam int EFF_H_BITS      = $clog2(HEIGHT_LIMIT + 1);
    localparam int SUM_BITS        = CHANNEL_BITS + 1;
    localparam int AVG_BITS        = CHANNEL_BITS + 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_HEIGHT = CFG_INDEX_BITS'(1);

    typedef struct packed {
        logic                restart;
        logic                hold_en;
        logic                wr_en;
        logic                rd_en;
        logic [IDX_BITS-1:0] idx;
    } t_lane_ctrl;

endpackage

[rtl/bds_ram.sv]
// ----------------------------------------------------------------------------
// bds_ram: generic simple dual-port RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module bds_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/bds_lane.sv]
// ----------------------------------------------------------------------------
// bds_lane: one colour channel of the 2x2 box downsampler
// Holds the left pixel, forms horizontal pair sums, keeps even-row sums in
// its line store and produces the rounded block average on odd rows.
// ----------------------------------------------------------------------------
module bds_lane (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bds_pkg::t_lane_ctrl              i_ctrl,
    input  logic [bds_pkg::CHANNEL_BITS-1:0] i_pixel,
    output logic [bds_pkg::CHANNEL_BITS-1:0] o_average
);

    logic [bds_pkg::CHANNEL_BITS-1:0] r_held;
    logic [bds_pkg::CHANNEL_BITS-1:0] n_held;
    logic [bds_pkg::SUM_BITS-1:0]     r_pair;
    logic [bds_pkg::SUM_BITS-1:0]     pair_sum;
    logic [bds_pkg::SUM_BITS-1:0]     line_sum;
    logic [bds_pkg::AVG_BITS-1:0]     block_sum;

    assign pair_sum = bds_pkg::SUM_BITS'(r_held) + bds_pkg::SUM_BITS'(i_pixel);

    always_comb begin
        n_held = r_held;
        if (i_ctrl.restart) begin
            n_held = '0;
        end else if (i_ctrl.hold_en) begin
            n_held = i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else begin
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_pair <= pair_sum;
        end
    end

    bds_ram #(
        .WIDTH (bds_pkg::SUM_BITS),
        .DEPTH (bds_pkg::LINE_DEPTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctrl.wr_en),
        .i_wr_addr (i_ctrl.idx),
        .i_wr_data (pair_sum),
        .i_rd_en   (i_ctrl.rd_en),
        .i_rd_addr (i_ctrl.idx),
        .o_rd_data (line_sum)
    );

    assign block_sum = bds_pkg::AVG_BITS'(r_pair) + bds_pkg::AVG_BITS'(line_sum)
                     + bds_pkg::AVG_BITS'(2);
    assign o_average = block_sum[bds_pkg::AVG_BITS-1:2];

endmodule

[rtl/bds_ctrl.sv]
// ----------------------------------------------------------------------------
// bds_ctrl: frame position and lane control of the 2x2 box downsampler
// Keeps the size registers and the column and row counters, and decides for
// each accepted pixel whether the lanes hold it, store a pair or read back.
// ----------------------------------------------------------------------------
module bds_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr,
    input  logic [bds_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [bds_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                               i_accept,
    output bds_pkg::t_lane_ctrl                o_ctrl,
    output logic                               o_produce,
    output logic                               o_last
);

    logic [bds_pkg::WIDTH_REG_BITS-1:0]  r_width;
    logic [bds_pkg::HEIGHT_REG_BITS-1:0] r_height;
    logic [bds_pkg::COL_BITS-1:0]        r_col;
    logic [bds_pkg::COL_BITS-1:0]        n_col;
    logic [bds_pkg::ROW_BITS-1:0]        r_row;
    logic [bds_pkg::ROW_BITS-1:0]        n_row;
    logic [bds_pkg::EFF_W_BITS-1:0]      eff_w;
    logic [bds_pkg::EFF_H_BITS-1:0]      eff_h;
    logic [bds_pkg::EFF_W_BITS-2:0]      pair_w;
    logic [bds_pkg::EFF_H_BITS-2:0]      pair_h;
    logic                                size_ok;
    logic                                col_used;
    logic                                row_used;
    logic                                active;
    logic                                col_wrap;
    logic                                row_wrap;
    logic                                restart;

    assign eff_w = (32'(r_width) > 32'(bds_pkg::MAX_WIDTH))
                 ? bds_pkg::EFF_W_BITS'(bds_pkg::MAX_WIDTH)
                 : bds_pkg::EFF_W_BITS'(r_width);
    assign eff_h = (32'(r_height) > 32'(bds_pkg::HEIGHT_LIMIT))
                 ? bds_pkg::EFF_H_BITS'(bds_pkg::HEIGHT_LIMIT)
                 : bds_pkg::EFF_H_BITS'(r_height);
    assign pair_w = eff_w[bds_pkg::EFF_W_BITS-1:1];
    assign pair_h = eff_h[bds_pkg::EFF_H_BITS-1:1];

    assign size_ok  = (eff_w != '0) && (eff_h != '0);
    assign col_used = 32'(r_col >> 1) < 32'(pair_w);
    assign row_used = 32'(r_row >> 1) < 32'(pair_h);
    assign active   = i_accept && size_ok && col_used && row_used;
    assign col_wrap = (32'(r_col) + 32'd1) >= 32'(eff_w);
    assign row_wrap = (32'(r_row) + 32'd1) >= 32'(eff_h);

    assign restart = i_cfg_wr && ((i_cfg_index == bds_pkg::REG_SOURCE_WIDTH)
                               || (i_cfg_index == bds_pkg::REG_SOURCE_HEIGHT));

    assign o_ctrl.restart = restart;
    assign o_ctrl.hold_en = active && !r_col[0];
    assign o_ctrl.wr_en   = active && r_col[0] && !r_row[0];
    assign o_ctrl.rd_en   = active && r_col[0] && r_row[0];
    assign o_ctrl.idx     = bds_pkg::IDX_BITS'(r_col >> 1);
    assign o_produce      = o_ctrl.rd_en;
    assign o_last         = (32'(r_col) == 32'(pair_w) * 2 - 1)
                         && (32'(r_row) == 32'(pair_h) * 2 - 1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (restart) begin
            n_col = '0;
            n_row = '0;
        end else if (i_accept && size_ok) begin
            if (col_wrap) begin
                n_col = '0;
                n_row = row_wrap ? '0 : r_row + bds_pkg::ROW_BITS'(1);
            end else begin
                n_col = r_col + bds_pkg::COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            if (i_cfg_wr && (i_cfg_index == bds_pkg::REG_SOURCE_WIDTH)) begin
                r_width <= i_cfg_data[bds_pkg::WIDTH_REG_BITS-1:0];
            end
            if (i_cfg_wr && (i_cfg_index == bds_pkg::REG_SOURCE_HEIGHT)) begin
                r_height <= i_cfg_data[bds_pkg::HEIGHT_REG_BITS-1:0];
            end
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eff_w != '0) |-> (32'(r_col) < 32'(eff_w)))
        else $error("column counter outside the frame width");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eff_h != '0) |-> (32'(r_row) < 32'(eff_h)))
        else $error("row counter outside the frame height");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart |=> (r_col == '0) && (r_row == '0))
        else $error("size write did not restart the frame");

endmodule

[rtl/box_downsample_2x2.sv]
// ----------------------------------------------------------------------------
// box_downsample_2x2: 2x2 box-filter downsampler for a raster pixel stream
// Four channel lanes average each 2x2 block of the source into one pixel.
// ----------------------------------------------------------------------------
// Usage:
// Source pixels enter in raster order on the input channel (i_valid,
// o_ready) with four 16-bit channels each. Results leave on the output
// channel (o_valid, i_ready); o_last_pixel marks the final pixel of a frame.
// The frame size is written through the configuration channel (i_cfg_valid,
// o_cfg_ready, index 0 width, index 1 height) while no transaction is in
// flight; each such write restarts the frame.
// One source pixel is taken every clock cycle unless the receiver stalls with
// both result stages full. Each lane's line store has one write and one read
// port and sees at most one access per pixel, which sets that rate. A result
// enters the lane stage, then the output register, after its last pixel.
// Reset clears the size registers to zero, so no result is given until both
// sizes are written. The line stores need no clearing pass. When the
// receiver stalls, one result waits in the output register and a second in
// the lane stage; further input is then held off until the output drains.
// ----------------------------------------------------------------------------
module box_downsample_2x2 (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bds_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [bds_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [bds_pkg::CHANNEL_BITS-1:0]   i_red_in,
    input  logic [bds_pkg::CHANNEL_BITS-1:0]   i_green_in,
    input  logic [bds_pkg::CHANNEL_BITS-1:0]   i_blue_in,
    input  logic [bds_pkg::CHANNEL_BITS-1:0]   i_alpha_in,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [bds_pkg::CHANNEL_BITS-1:0]   o_red_out,
    output logic [bds_pkg::CHANNEL_BITS-1:0]   o_green_out,
    output logic [bds_pkg::CHANNEL_BITS-1:0]   o_blue_out,
    output logic [bds_pkg::CHANNEL_BITS-1:0]   o_alpha_out,
    output logic                               o_last_pixel
);

    bds_pkg::t_lane_ctrl              lane_ctrl;
    logic                             accept;
    logic                             produce;
    logic                             last;
    logic                             s1_adv;
    logic [bds_pkg::CHANNEL_BITS-1:0] lane_px  [bds_pkg::NUM_LANES];
    logic [bds_pkg::CHANNEL_BITS-1:0] lane_avg [bds_pkg::NUM_LANES];
    logic [bds_pkg::CHANNEL_BITS-1:0] r_out_px [bds_pkg::NUM_LANES];
    logic                             r_s1_valid;
    logic                             n_s1_valid;
    logic                             r_s1_last;
    logic                             r_out_valid;
    logic                             n_out_valid;
    logic                             r_out_last;

    assign o_cfg_ready = 1'b1;

    assign s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    bds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .o_ctrl      (lane_ctrl),
        .o_produce   (produce),
        .o_last      (last)
    );

    assign lane_px[0] = i_red_in;
    assign lane_px[1] = i_green_in;
    assign lane_px[2] = i_blue_in;
    assign lane_px[3] = i_alpha_in;

    for (genvar g = 0; g < bds_pkg::NUM_LANES; g++) begin : g_lane
        bds_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (lane_ctrl),
            .i_pixel   (lane_px[g]),
            .o_average (lane_avg[g])
        );
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept && produce) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && produce) begin
            r_s1_last <= last;
        end
        if (s1_adv) begin
            r_out_last <= r_s1_last;
            for (int k = 0; k < bds_pkg::NUM_LANES; k++) begin
                r_out_px[k] <= lane_avg[k];
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_red_out    = r_out_px[0];
    assign o_green_out  = r_out_px[1];
    assign o_blue_out   = r_out_px[2];
    assign o_alpha_out  = r_out_px[3];
    assign o_last_pixel = r_out_last;

    a_full_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_ready) |-> !o_ready)
        else $error("input taken while both result stages are full and stalled");

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("lane stage advanced without filling the output register");

    a_last_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && produce && last) |=> (r_s1_valid && r_s1_last))
        else $error("final block of the frame lost its marker");

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 2x2 box downsampler
// Source frames of many sizes are streamed in raster order, with random gaps
// on the pixel input and random stalls on the result output. A behavioural
// copy of the downsampler predicts every block average, and each result
// transaction is compared with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT   = 6_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int SHORT_BURST   = 48;

    localparam logic [bds_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_2 =
        bds_pkg::CFG_INDEX_BITS'(2);
    localparam logic [bds_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_3 =
        bds_pkg::CFG_INDEX_BITS'(3);

    // Channel 0 is red, then green, blue and alpha.
    typedef logic [bds_pkg::NUM_LANES-1:0][bds_pkg::CHANNEL_BITS-1:0] t_pixel;

    typedef struct {
        t_pixel value;
        logic   last;
    } t_block_avg;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [bds_pkg::CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [bds_pkg::CFG_DATA_BITS-1:0]  i_cfg_data;
    logic                               i_valid;
    logic                               o_ready;
    logic [bds_pkg::CHANNEL_BITS-1:0]   i_red_in;
    logic [bds_pkg::CHANNEL_BITS-1:0]   i_green_in;
    logic [bds_pkg::CHANNEL_BITS-1:0]   i_blue_in;
    logic [bds_pkg::CHANNEL_BITS-1:0]   i_alpha_in;
    logic                               o_valid;
    logic                               i_ready;
    logic [bds_pkg::CHANNEL_BITS-1:0]   o_red_out;
    logic [bds_pkg::CHANNEL_BITS-1:0]   o_green_out;
    logic [bds_pkg::CHANNEL_BITS-1:0]   o_blue_out;
    logic [bds_pkg::CHANNEL_BITS-1:0]   o_alpha_out;
    logic                               o_last_pixel;

    box_downsample_2x2 u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_alpha_in   (i_alpha_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_alpha_out  (o_alpha_out),
        .o_last_pixel (o_last_pixel)
    );

    // Predicted downsampler state.
    logic [bds_pkg::WIDTH_REG_BITS-1:0]  frame_width  = '0;
    logic [bds_pkg::HEIGHT_REG_BITS-1:0] frame_height = '0;
    logic [bds_pkg::SUM_BITS-1:0]        line_sums [bds_pkg::NUM_LANES][bds_pkg::LINE_DEPTH];
    t_pixel                              held_pixel   = '0;
    int unsigned                         col_pos      = 0;
    int unsigned                         row_pos      = 0;

    t_block_avg pending_averages[$];
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    int         source_quiet   = 0;
    int         sink_quiet     = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("box_downsample_2x2 verification failed");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, and now and then a stretch of none.
    function automatic int pick_gap(inout int quiet);
        int roll;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        roll = $urandom_range(0, 199);
        if (roll < 2) begin
            quiet = $urandom_range(30, 120);
            return 0;
        end
        if (roll < 100)
            return 0;
        if (roll < 170)
            return $urandom_range(1, 3);
        if (roll < 194)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_pixel make_pixel(input logic [bds_pkg::CHANNEL_BITS-1:0] red,
                                          input logic [bds_pkg::CHANNEL_BITS-1:0] green,
                                          input logic [bds_pkg::CHANNEL_BITS-1:0] blue,
                                          input logic [bds_pkg::CHANNEL_BITS-1:0] alpha);
        return {alpha, blue, green, red};
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel px;
        int     roll;
        for (int c = 0; c < bds_pkg::NUM_LANES; c++) begin
            roll = $urandom_range(0, 9);
            if (roll == 0)
                px[c] = '0;
            else if (roll == 1)
                px[c] = '1;
            else
                px[c] = bds_pkg::CHANNEL_BITS'($urandom_range(0, 65535));
        end
        return px;
    endfunction

    function automatic void restart_frame();
        col_pos    = 0;
        row_pos    = 0;
        held_pixel = '0;
    endfunction

    // Advances the predicted frame position by one source pixel and queues
    // the block average when the pixel completes a 2x2 block.
    function automatic void accumulate_pixel(input t_pixel px);
        int unsigned                  eff_w;
        int unsigned                  eff_h;
        int unsigned                  pair_w;
        int unsigned                  pair_h;
        int unsigned                  idx;
        logic [bds_pkg::AVG_BITS-1:0] sum;
        t_block_avg                   avg;
        eff_w = (frame_width > bds_pkg::MAX_WIDTH) ? bds_pkg::MAX_WIDTH : frame_width;
        eff_h = (frame_height > bds_pkg::HEIGHT_LIMIT) ? bds_pkg::HEIGHT_LIMIT : frame_height;
        if (eff_w == 0 || eff_h == 0)
            return;
        pair_w = eff_w / 2;
        pair_h = eff_h / 2;
        if ((col_pos / 2) < pair_w && (row_pos / 2) < pair_h) begin
            if (col_pos % 2 == 0) begin
                held_pixel = px;
            end else begin
                idx = (col_pos / 2) % bds_pkg::LINE_DEPTH;
                if (row_pos % 2 == 0) begin
                    for (int c = 0; c < bds_pkg::NUM_LANES; c++)
                        line_sums[c][idx] = bds_pkg::SUM_BITS'(held_pixel[c])
                                          + bds_pkg::SUM_BITS'(px[c]);
                end else begin
                    for (int c = 0; c < bds_pkg::NUM_LANES; c++) begin
                        sum = bds_pkg::AVG_BITS'(line_sums[c][idx])
                            + bds_pkg::AVG_BITS'(held_pixel[c])
                            + bds_pkg::AVG_BITS'(px[c]);
                        avg.value[c] = sum[bds_pkg::AVG_BITS-1:2]
                                     + bds_pkg::CHANNEL_BITS'(sum[1]);
                    end
                    avg.last = (col_pos == pair_w * 2 - 1) && (row_pos == pair_h * 2 - 1);
                    pending_averages.push_back(avg);
                end
            end
        end
        col_pos++;
        if (col_pos >= eff_w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= eff_h)
                row_pos = 0;
        end
    endfunction

    task automatic write_reg(input logic [bds_pkg::CFG_INDEX_BITS-1:0] index,
                             input logic [bds_pkg::CFG_DATA_BITS-1:0]  data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            bds_pkg::REG_SOURCE_WIDTH: begin
                frame_width = data[bds_pkg::WIDTH_REG_BITS-1:0];
                restart_frame();
            end
            bds_pkg::REG_SOURCE_HEIGHT: begin
                frame_height = data[bds_pkg::HEIGHT_REG_BITS-1:0];
                restart_frame();
            end
            default: ;
        endcase
        repeat ($urandom_range(1, 3)) @(posedge i_clk);
    endtask

    task automatic send_pixel(input t_pixel px);
        int gap;
        gap = pick_gap(source_quiet);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_red_in   <= px[0];
        i_green_in <= px[1];
        i_blue_in  <= px[2];
        i_alpha_in <= px[3];
        do @(posedge i_clk); while (!o_ready);
        accumulate_pixel(px);
    endtask

    task automatic send_random_pixels(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(random_pixel());
    endtask

    // Stops the source and waits until every predicted average has arrived.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_averages.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_zero_size();
        send_random_pixels(2);
        drain_results();
        write_reg(bds_pkg::REG_SOURCE_HEIGHT, 13'd4);
        send_random_pixels(2);
        drain_results();
        write_reg(bds_pkg::REG_SOURCE_WIDTH, 13'd4);
        write_reg(bds_pkg::REG_SOURCE_HEIGHT, 13'd0);
        send_random_pixels(2);
        drain_results();
    endtask

    task automatic test_channel_extremes();
        t_pixel full_px;
        t_pixel blank_px;
        t_pixel odd_bits;
        t_pixel even_bits;
        full_px   = '1;
        blank_px  = '0;
        odd_bits  = {bds_pkg::NUM_LANES{16'hAAAA}};
        even_bits = {bds_pkg::NUM_LANES{16'h5555}};
        write_reg(bds_pkg::REG_SOURCE_WIDTH, 13'd4);
        write_reg(bds_pkg::REG_SOURCE_HEIGHT, 13'd2);
        for (int r = 0; r < 2; r++) begin
            send_pixel(full_px);
            send_pixel(full_px);
            send_pixel(blank_px);
            send_pixel(blank_px);
        end
        // Sums that sit on and just below the rounding step.
        send_pixel(make_pixel(16'd1, 16'd1, 16'hFFFF, 16'd3));
        send_pixel(make_pixel(16'd1, 16'd0, 16'hFFFF, 16'd0));
        send_pixel(odd_bits);
        send_pixel(even_bits);
        send_pixel(make_pixel(16'd0, 16'd0, 16'hFFFF, 16'd0));
        send_pixel(make_pixel(16'd0, 16'd0, 16'hFFFE, 16'd0));
        send_pixel(even_bits);
        send_pixel(odd_bits);
        drain_results();
    endtask

    task automatic test_odd_sizes();
        // The top data bit lies beyond the width register and is dropped.
        write_reg(bds_pkg::REG_SOURCE_WIDTH, 13'h1005);
        write_reg(bds_pkg::REG_SOURCE_HEIGHT, 13'd3);
        send_random_pixels(7);
        drain_results();
        // Writes to unused indexes must leave the frame position alone.
        write_reg(REG_SPARE_2, 13'h1FFF);
        write_reg(REG_SPARE_3, 13'h0000);
        send_random_pixels(13);
        drain_results();
    endtask

    task automatic test_full_scale();
        write_reg(bds_pkg::REG_SOURCE_WIDTH, 13'd2048);
        write_reg(bds_pkg::REG_SOURCE_HEIGHT, 13'd4096);
        send_random_pixels(6);
        drain_results();
    endtask

    task automatic test_wide_frame();
        write_reg(bds_pkg::REG_SOURCE_WIDTH, 13'd4095);
        write_reg(bds_pkg::REG_SOURCE_HEIGHT, 13'd2);
        send_random_pixels(SHORT_BURST);
        drain_results();
    endtask

    task automatic test_tall_frame();
        write_reg(bds_pkg::REG_SOURCE_HEIGHT, 13'd8191);
        write_reg(bds_pkg::REG_SOURCE_WIDTH, 13'd2);
        send_random_pixels(SHORT_BURST);
        drain_results();
    endtask

    task automatic test_random_frames();
        int sent;
        int width;
        int height;
        int frame_px;
        int count;
        int pause_at;
        int roll;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 19);
            width = (roll < 14) ? $urandom_range(2, 10) :
                    (roll < 18) ? $urandom_range(11, 40) :
                    (roll == 18) ? 1 : 0;
            roll = $urandom_range(0, 19);
            height = (roll < 14) ? $urandom_range(2, 8) :
                     (roll < 18) ? $urandom_range(9, 16) :
                     (roll == 18) ? 1 : 0;
            if ($urandom_range(0, 1) == 1) begin
                write_reg(bds_pkg::REG_SOURCE_WIDTH,
                          bds_pkg::CFG_DATA_BITS'(width | ($urandom_range(0, 1) << 12)));
                write_reg(bds_pkg::REG_SOURCE_HEIGHT, bds_pkg::CFG_DATA_BITS'(height));
            end else begin
                write_reg(bds_pkg::REG_SOURCE_HEIGHT, bds_pkg::CFG_DATA_BITS'(height));
                write_reg(bds_pkg::REG_SOURCE_WIDTH,
                          bds_pkg::CFG_DATA_BITS'(width | ($urandom_range(0, 1) << 12)));
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_2 : REG_SPARE_3,
                          bds_pkg::CFG_DATA_BITS'($urandom_range(0, 8191)));
            frame_px = width * height;
            if (frame_px == 0)
                count = 4;
            else
                count = frame_px * $urandom_range(1, 3) + $urandom_range(0, frame_px - 1);
            if (count > 300)
                count = 300;
            pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, count - 1) : -1;
            for (int i = 0; i < count; i++) begin
                if (i == pause_at)
                    drain_results();
                send_pixel(random_pixel());
            end
            if (frame_px != 0)
                sent += count;
            drain_results();
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_red_in    <= '0;
        i_green_in  <= '0;
        i_blue_in   <= '0;
        i_alpha_in  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_size();
        test_channel_extremes();
        test_odd_sizes();
        test_full_scale();
        test_wide_frame();
        test_tall_frame();
        test_random_frames();

        drain_results();
        if (mismatch_count == 0)
            $display("box_downsample_2x2 verification clean");
        else
            $display("box_downsample_2x2 verification failed");
        $finish;
    end

    initial begin : result_sink
        int stall;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        i_ready <= 1'b1;
        forever begin
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            stall = pick_gap(sink_quiet);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_block_avg want;
        t_pixel     got;
        string      lane_name [bds_pkg::NUM_LANES];
        lane_name = '{"red", "green", "blue", "alpha"};
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_alpha_out, o_blue_out, o_green_out, o_red_out};
            if (pending_averages.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h last %b",
                         $time, got, o_last_pixel);
                mismatch_count++;
            end else begin
                want = pending_averages.pop_front();
                for (int c = 0; c < bds_pkg::NUM_LANES; c++) begin
                    if (got[c] !== want.value[c]) begin
                        $display("%0t: %s mismatch, expected %h, actual %h",
                                 $time, lane_name[c], want.value[c], got[c]);
                        mismatch_count++;
                    end
                end
                if (o_last_pixel !== want.last) begin
                    $display("%0t: last_pixel mismatch, expected %b, actual %b",
                             $time, want.last, o_last_pixel);
                    mismatch_count++;
                end
            end
        end
    end

endmodule
